[rtl/btl_pkg.sv]
package btl_pkg;

    // Fixed widths of the ports.
    localparam int PRICE_W    = 24;
    localparam int INDEX_W    = 12;
    localparam int THRESH_W   = 23;
    localparam int LABEL_W    = 2;
    localparam int FEE_W      = 16;
    localparam int PM_W       = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Sample values in 1/16 units before conversion to the stored format.
    localparam int RAW_W = 27;

    // Search bounds in 1/16 units.
    localparam int TOP_SIXTEENTHS  = 8000440;
    localparam int HALF_SIXTEENTHS = 8;

    // Register reset values.
    localparam logic [FEE_W-1:0] FEE_RESET = 16'd4;
    localparam logic [PM_W-1:0]  PM_RESET  = 10'd64;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FEE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PM  = 2'd1;

    // Function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Label codes.
    localparam logic [LABEL_W-1:0] LABEL_HOLD = 2'd0;
    localparam logic [LABEL_W-1:0] LABEL_BUY  = 2'd1;
    localparam logic [LABEL_W-1:0] LABEL_SELL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY,
        ST_CHECK,
        ST_MARGIN,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    // Controls from the sequencer to the tally unit.
    typedef struct packed {
        logic clear;
        logic issue;
    } tally_ctrl_t;

endpackage

[rtl/btl_ram.sv]
module btl_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/btl_tally.sv]
module btl_tally #(
    parameter int DW   = 27,
    parameter int LW   = 23,
    parameter int CW   = 29,
    parameter int CNTW = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  btl_pkg::tally_ctrl_t  ctrl,
    input  logic [DW-1:0]         ask_data,
    input  logic [DW-1:0]         bid_data,
    input  logic [LW-1:0]         mid,
    input  logic signed [CW-1:0]  sell_line,
    output logic                  buy_wins
);

    logic            valid_reg;
    logic [CNTW-1:0] buys_reg;
    logic [CNTW-1:0] sells_reg;
    logic            is_buy;
    logic            is_sell;

    // Read data arrives in the cycle after the address was issued.
    assign is_buy  = $signed(CW'($signed(ask_data))) < $signed(CW'(mid));
    assign is_sell = $signed(CW'($signed(bid_data))) > sell_line;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            buys_reg  <= '0;
            sells_reg <= '0;
        end else begin
            valid_reg <= ctrl.issue;
            if (ctrl.clear) begin
                buys_reg  <= '0;
                sells_reg <= '0;
            end else if (valid_reg) begin
                buys_reg  <= buys_reg + CNTW'(is_buy);
                sells_reg <= sells_reg + CNTW'(is_sell);
            end
        end
    end

    assign buy_wins = buys_reg > sells_reg;

endmodule

[rtl/balanced_threshold_labeler_unit.sv]
// Balanced threshold labeler. Load words (func 0) store one sample each as an
// ask and a bid in the fixed-point format set by FRAC_BITS, at the next free
// entry of two sample RAMs of MAX_SAMPLES entries; loads that find the store
// full are dropped and raise the overflow flag for that set. A load marked
// last then runs a bisection search for the price line: each pass runs the
// check, margin, scan, drain and decide states (scan and drain are skipped
// for an empty set), and every sample is read once per pass through the single
// read port of each RAM. About log2(8000440 / 8), or twenty, passes are needed,
// and the search ends with one search result word. A label query (func 1)
// reads the RAM in idle, forms the label from the read data in the query state
// and returns one label word. Configuration writes to fee and profit_multiplier
// are taken at any time on their own channel, but should be issued only while
// the block is idle.
module balanced_threshold_labeler_unit #(
    parameter int MAX_SAMPLES = 4096,
    parameter int FRAC_BITS   = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic signed [btl_pkg::PRICE_W-1:0] s_price,
    input  logic signed [btl_pkg::PRICE_W-1:0] s_spread,
    input  logic                              s_last,
    input  logic [btl_pkg::INDEX_W-1:0]       s_index,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_is_label,
    output logic [btl_pkg::THRESH_W-1:0]      m_threshold,
    output logic [btl_pkg::LABEL_W-1:0]       m_label,
    output logic                              m_overflow,
    output logic                              m_bad_index,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [btl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [btl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Conversion from 1/16 units: shift up for finer formats, down for coarser ones.
    localparam int UP   = (FRAC_BITS >= 4) ? FRAC_BITS - 4 : 0;
    localparam int DN   = (FRAC_BITS < 4) ? 4 - FRAC_BITS : 0;
    localparam int SW   = btl_pkg::RAW_W + UP;
    localparam int DW   = SW - DN;
    localparam int CW   = DW + 2;
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CNTW = $clog2(MAX_SAMPLES + 1);
    localparam int TOP_LINE  = (btl_pkg::TOP_SIXTEENTHS << UP) >> DN;
    localparam int HALF_LINE = (btl_pkg::HALF_SIXTEENTHS << UP) >> DN;
    localparam int LW   = $clog2(TOP_LINE + 1);
    localparam int IW   = (CNTW > btl_pkg::INDEX_W) ? CNTW : btl_pkg::INDEX_W;
    localparam int QAW  = AW + btl_pkg::INDEX_W;

    btl_pkg::state_t state_reg, state_next;

    // Control and search state.
    logic [CNTW-1:0]             count_reg, count_next;
    logic                        dropped_reg, dropped_next;
    logic                        closed_reg, closed_next;
    logic [LW-1:0]               line_reg, line_next;
    logic [LW-1:0]               low_reg, low_next;
    logic [LW-1:0]               high_reg, high_next;
    logic [LW-1:0]               mid_reg, mid_next;
    logic signed [CW-1:0]        sell_reg, sell_next;
    logic [CNTW-1:0]             scan_reg, scan_next;
    logic                        bad_reg, bad_next;

    // Registers and the margin derived from them.
    logic [btl_pkg::FEE_W-1:0]   fee_reg;
    logic [btl_pkg::PM_W-1:0]    pm_reg;
    logic [DW-1:0]               margin_reg;

    // Result word register.
    logic                        out_valid_reg, out_valid_next;
    logic                        out_is_label_reg, out_is_label_next;
    logic [btl_pkg::THRESH_W-1:0] out_thresh_reg, out_thresh_next;
    logic [btl_pkg::LABEL_W-1:0] out_label_reg, out_label_next;
    logic                        out_ovf_reg, out_ovf_next;
    logic                        out_bad_reg, out_bad_next;

    logic                        in_fire, load_fire, query_fire;
    logic [CNTW-1:0]             count_base;
    logic                        dropped_base;
    logic                        room;
    logic                        more_passes;
    logic                        scan_last;
    logic [LW:0]                 sum_lh;
    logic [LW-1:0]               half_sum;
    logic [btl_pkg::THRESH_W-1:0] half_sum_out;
    logic [btl_pkg::THRESH_W-1:0] line_out;

    logic [btl_pkg::PRICE_W-1:0] p_abs, s_abs;
    logic signed [btl_pkg::RAW_W-1:0] ask16, bid16;
    logic signed [SW-1:0]        ask_wide, bid_wide;
    logic [DW-1:0]               ask_store, bid_store;
    logic [btl_pkg::RAW_W-1:0]   margin16;
    logic [SW-1:0]               margin_wide;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr, query_addr;
    logic [QAW-1:0]              query_wide;
    logic [DW-1:0]               ask_rdata, bid_rdata;
    logic                        buy_wins;
    btl_pkg::tally_ctrl_t        tally_ctrl;

    logic signed [CW-1:0]        sell_line_now;
    logic                        q_buy, q_sell;

    // ---------------------------------------------------------------------
    // Handshakes.
    // ---------------------------------------------------------------------
    assign in_fire    = s_valid && s_ready;
    assign load_fire  = in_fire && (s_func == btl_pkg::FUNC_LOAD);
    assign query_fire = in_fire && (s_func == btl_pkg::FUNC_QUERY);
    assign cfg_ready  = 1'b1;

    // ---------------------------------------------------------------------
    // Sample conversion. The ask is 2|p| + |s| and the bid 2|p| - |s| in
    // 1/16 units, then scaled to the stored format with floor rounding.
    // ---------------------------------------------------------------------
    assign p_abs = s_price[btl_pkg::PRICE_W-1] ? btl_pkg::PRICE_W'(-s_price)
                                               : btl_pkg::PRICE_W'(s_price);
    assign s_abs = s_spread[btl_pkg::PRICE_W-1] ? btl_pkg::PRICE_W'(-s_spread)
                                                : btl_pkg::PRICE_W'(s_spread);
    assign ask16 = btl_pkg::RAW_W'({p_abs, 1'b0}) + btl_pkg::RAW_W'(s_abs);
    assign bid16 = btl_pkg::RAW_W'({p_abs, 1'b0}) - btl_pkg::RAW_W'(s_abs);
    assign ask_wide  = (SW'(ask16) <<< UP) >>> DN;
    assign bid_wide  = (SW'(bid16) <<< UP) >>> DN;
    assign ask_store = ask_wide[DW-1:0];
    assign bid_store = bid_wide[DW-1:0];

    // The margin is profit_multiplier * fee / 8 in price units, that is
    // twice the product in 1/16 units.
    assign margin16    = {btl_pkg::RAW_W'(26'(pm_reg) * 26'(fee_reg))} << 1;
    assign margin_wide = (SW'(margin16) << UP) >> DN;

    // ---------------------------------------------------------------------
    // Set bookkeeping. A load that finds the set closed starts a new one.
    // ---------------------------------------------------------------------
    assign count_base   = closed_reg ? '0 : count_reg;
    assign dropped_base = closed_reg ? 1'b0 : dropped_reg;
    assign room         = count_base < CNTW'(MAX_SAMPLES);

    assign more_passes = (high_reg - low_reg) > LW'(HALF_LINE);
    assign scan_last   = scan_reg == (count_reg - CNTW'(1));
    assign sum_lh      = {1'b0, low_reg} + {1'b0, high_reg};
    assign half_sum    = sum_lh[LW:1];

    // The threshold port carries the low bits of the line.
    assign half_sum_out = btl_pkg::THRESH_W'((LW + btl_pkg::THRESH_W)'(half_sum));
    assign line_out     = btl_pkg::THRESH_W'((LW + btl_pkg::THRESH_W)'(line_reg));

    // ---------------------------------------------------------------------
    // Sample RAMs. Writes come from loads, reads from queries in idle and
    // from the scan during the search; the two never target the same cycle.
    // ---------------------------------------------------------------------
    assign ram_we     = load_fire && room;
    assign ram_waddr  = count_base[AW-1:0];
    assign query_wide = QAW'(s_index);
    assign query_addr = query_wide[AW-1:0];

    btl_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_SAMPLES)
    ) u_ask_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ask_store),
        .raddr (ram_raddr),
        .rdata (ask_rdata)
    );

    btl_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_SAMPLES)
    ) u_bid_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (bid_store),
        .raddr (ram_raddr),
        .rdata (bid_rdata)
    );

    // Buy and sell counts of the current pass.
    btl_tally #(
        .DW   (DW),
        .LW   (LW),
        .CW   (CW),
        .CNTW (CNTW)
    ) u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tally_ctrl),
        .ask_data  (ask_rdata),
        .bid_data  (bid_rdata),
        .mid       (mid_reg),
        .sell_line (sell_reg),
        .buy_wins  (buy_wins)
    );

    // ---------------------------------------------------------------------
    // Label of a queried sample, from the RAM data of the previous cycle.
    // ---------------------------------------------------------------------
    assign sell_line_now = $signed(CW'(line_reg)) + $signed(CW'(margin_reg));
    assign q_buy  = $signed(CW'($signed(ask_rdata))) < $signed(CW'(line_reg));
    assign q_sell = $signed(CW'($signed(bid_rdata))) >= sell_line_now;

    // ---------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            btl_pkg::ST_IDLE: begin
                if (load_fire && s_last) begin
                    state_next = btl_pkg::ST_CHECK;
                end else if (query_fire) begin
                    state_next = btl_pkg::ST_QUERY;
                end
            end
            btl_pkg::ST_QUERY: begin
                state_next = btl_pkg::ST_IDLE;
            end
            btl_pkg::ST_CHECK: begin
                state_next = more_passes ? btl_pkg::ST_MARGIN : btl_pkg::ST_IDLE;
            end
            btl_pkg::ST_MARGIN: begin
                state_next = (count_reg == '0) ? btl_pkg::ST_DECIDE : btl_pkg::ST_SCAN;
            end
            btl_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = btl_pkg::ST_DRAIN;
                end
            end
            btl_pkg::ST_DRAIN: begin
                state_next = btl_pkg::ST_DECIDE;
            end
            btl_pkg::ST_DECIDE: begin
                state_next = btl_pkg::ST_CHECK;
            end
            default: begin
                state_next = btl_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: outputs. Input words are taken only in idle and only when
    // the result register is free or being emptied, so a search or query
    // result always finds it free.
    // ---------------------------------------------------------------------
    always_comb begin
        s_ready          = 1'b0;
        ram_raddr        = scan_reg[AW-1:0];
        tally_ctrl.clear = 1'b0;
        tally_ctrl.issue = 1'b0;
        case (state_reg)
            btl_pkg::ST_IDLE: begin
                s_ready   = !out_valid_reg || m_ready;
                ram_raddr = query_addr;
            end
            btl_pkg::ST_MARGIN: begin
                tally_ctrl.clear = 1'b1;
            end
            btl_pkg::ST_SCAN: begin
                tally_ctrl.issue = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath next values.
    // ---------------------------------------------------------------------
    always_comb begin
        count_next        = count_reg;
        dropped_next      = dropped_reg;
        closed_next       = closed_reg;
        line_next         = line_reg;
        low_next          = low_reg;
        high_next         = high_reg;
        mid_next          = mid_reg;
        sell_next         = sell_reg;
        scan_next         = scan_reg;
        bad_next          = bad_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        out_is_label_next = out_is_label_reg;
        out_thresh_next   = out_thresh_reg;
        out_label_next    = out_label_reg;
        out_ovf_next      = out_ovf_reg;
        out_bad_next      = out_bad_reg;

        case (state_reg)
            btl_pkg::ST_IDLE: begin
                if (load_fire) begin
                    closed_next  = s_last;
                    count_next   = room ? count_base + CNTW'(1) : count_base;
                    dropped_next = dropped_base || !room;
                    low_next     = '0;
                    high_next    = LW'(TOP_LINE);
                end else if (query_fire) begin
                    bad_next = IW'(s_index) >= IW'(count_reg);
                end
            end
            btl_pkg::ST_QUERY: begin
                out_valid_next    = 1'b1;
                out_is_label_next = 1'b1;
                out_thresh_next   = line_out;
                out_ovf_next      = dropped_reg;
                out_bad_next      = bad_reg;
                if (bad_reg) begin
                    out_label_next = btl_pkg::LABEL_HOLD;
                end else if (q_buy) begin
                    out_label_next = btl_pkg::LABEL_BUY;
                end else if (q_sell) begin
                    out_label_next = btl_pkg::LABEL_SELL;
                end else begin
                    out_label_next = btl_pkg::LABEL_HOLD;
                end
            end
            btl_pkg::ST_CHECK: begin
                if (more_passes) begin
                    mid_next = half_sum;
                end else begin
                    line_next         = half_sum;
                    out_valid_next    = 1'b1;
                    out_is_label_next = 1'b0;
                    out_thresh_next   = half_sum_out;
                    out_label_next    = btl_pkg::LABEL_HOLD;
                    out_ovf_next      = dropped_reg;
                    out_bad_next      = 1'b0;
                end
            end
            btl_pkg::ST_MARGIN: begin
                sell_next = $signed(CW'(mid_reg)) + $signed(CW'(margin_reg));
                scan_next = '0;
            end
            btl_pkg::ST_SCAN: begin
                scan_next = scan_reg + CNTW'(1);
            end
            btl_pkg::ST_DECIDE: begin
                if (buy_wins) begin
                    high_next = mid_reg;
                end else begin
                    low_next = mid_reg;
                end
            end
            default: begin
                scan_next = scan_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= btl_pkg::ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            closed_reg    <= 1'b1;
            line_reg      <= '0;
            fee_reg       <= btl_pkg::FEE_RESET;
            pm_reg        <= btl_pkg::PM_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            closed_reg    <= closed_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == btl_pkg::CFG_FEE) begin
                    fee_reg <= cfg_data;
                end else if (cfg_index == btl_pkg::CFG_PM) begin
                    pm_reg <= cfg_data[btl_pkg::PM_W-1:0];
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        low_reg          <= low_next;
        high_reg         <= high_next;
        mid_reg          <= mid_next;
        sell_reg         <= sell_next;
        scan_reg         <= scan_next;
        bad_reg          <= bad_next;
        margin_reg       <= margin_wide[DW-1:0];
        out_is_label_reg <= out_is_label_next;
        out_thresh_reg   <= out_thresh_next;
        out_label_reg    <= out_label_next;
        out_ovf_reg      <= out_ovf_next;
        out_bad_reg      <= out_bad_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_is_label  = out_is_label_reg;
    assign m_threshold = out_thresh_reg;
    assign m_label     = out_label_reg;
    assign m_overflow  = out_ovf_reg;
    assign m_bad_index = out_bad_reg;

endmodule
